// ----- src/rspc_pkg.sv -----
// Shared types, constants and the CORDIC gain function for the range scan converter.
package rspc_pkg;

  localparam int RangeWidth          = 24;
  localparam int AngleWidth          = 32;
  localparam int PointWidth          = 25;
  localparam int CfgDataWidth        = 32;
  localparam int CfgIndexWidth       = 2;
  localparam int GuardBits           = 6;
  localparam int AtanEntries         = 24;
  localparam int CordicStagesDefault = 16;
  // Q2.30 gain reciprocal and the prescaled range (range * K with guard bits)
  localparam int GainWidth           = 31;
  localparam int ScaledWidth         = 31;
  // CORDIC datapath widths: x/y carry the guard bits plus headroom for the gain
  localparam int XyWidth             = 34;
  localparam int ZWidth              = 33;
  localparam int XyMax               = 2 ** (PointWidth - 1) - 1;
  localparam int XyMin               = -(2 ** (PointWidth - 1));

  // Arctangent of 2^-i in binary angle units (full turn is 2^32)
  localparam logic [AngleWidth-1:0] AtanBau [AtanEntries] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgLowerLimit = 2'd0,
    CfgUpperLimit = 2'd1,
    CfgStartAngle = 2'd2,
    CfgAngleStep  = 2'd3
  } cfg_index_t;

  // One beat moving down the rotation chain
  typedef struct packed {
    logic                       vld;
    logic signed [XyWidth-1:0]  x;
    logic signed [XyWidth-1:0]  y;
    logic signed [ZWidth-1:0]   z;
    logic                       kept;
    logic                       last;
  } cell_bus_t;

  // Reciprocal CORDIC gain in Q2.30 for a given stage count, evaluated at elaboration.
  // Square root and division are done bit by bit.
  function automatic longint unsigned gain_recip_q30(input int stages);
    longint unsigned p;
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    longint unsigned num;
    longint unsigned rem;
    longint unsigned quo;
    p = 64'd1 << 60;
    for (int i = 0; i < AtanEntries; i++) begin
      if (i < stages) begin
        p = p + (p >> (2 * i));
      end
    end
    v   = p;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) begin
        b = b >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    if (res == 64'd0) begin
      return 64'd1 << 30;
    end
    num = (64'd1 << 60) + (res >> 1);
    rem = 64'd0;
    quo = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      rem = (rem << 1) | ((num >> j) & 64'd1);
      if (rem >= res) begin
        rem = rem - res;
        quo = quo | (64'd1 << j);
      end
    end
    return quo;
  endfunction

endpackage

// ----- src/rspc_front.sv -----
// Front end: config registers, beam angle accumulator, limit check, gain prescale, pre-rotation.
module rspc_front #(
  parameter int CORDIC_STAGES = rspc_pkg::CordicStagesDefault
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  cfg_wr_en,
  input  logic [rspc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [rspc_pkg::CfgDataWidth-1:0]     cfg_data,
  input  logic                                  in_valid,
  input  logic [rspc_pkg::RangeWidth-1:0]       in_range_sample,
  input  logic                                  in_sweep_end,
  output rspc_pkg::cell_bus_t                   bus_out
);

  localparam int RW = rspc_pkg::RangeWidth;
  localparam int AW = rspc_pkg::AngleWidth;
  localparam int SW = rspc_pkg::ScaledWidth;
  localparam int XW = rspc_pkg::XyWidth;
  localparam int ZW = rspc_pkg::ZWidth;
  localparam int ProdWidth = RW + rspc_pkg::GainWidth;
  localparam int KShift = 30 - rspc_pkg::GuardBits;
  localparam logic [rspc_pkg::GainWidth-1:0] GainK =
    rspc_pkg::GainWidth'(rspc_pkg::gain_recip_q30(CORDIC_STAGES));
  localparam logic [ProdWidth-1:0] ProdRound = ProdWidth'(1) << (KShift - 1);

  logic [RW-1:0] lo_limit_r, lo_limit_nxt;
  logic [RW-1:0] hi_limit_r, hi_limit_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] step_r, step_nxt;
  logic [AW-1:0] offset_r, offset_nxt;

  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [RW-1:0] s1_range_r;
  logic [AW-1:0] s1_theta_r, s2_theta_r;
  logic          s1_kept_r, s1_last_r, s2_kept_r, s2_last_r;
  logic [SW-1:0] s2_scaled_r;
  logic [ProdWidth-1:0] prod;
  rspc_pkg::cell_bus_t  s3_nxt, s3_r;

  logic in_fire;
  logic flip;

  assign in_fire = in_valid && adv;

  always_comb begin
    lo_limit_nxt = lo_limit_r;
    hi_limit_nxt = hi_limit_r;
    start_nxt    = start_r;
    step_nxt     = step_r;
    if (cfg_wr_en) begin
      case (rspc_pkg::cfg_index_t'(cfg_index))
        rspc_pkg::CfgLowerLimit: lo_limit_nxt = cfg_data[RW-1:0];
        rspc_pkg::CfgUpperLimit: hi_limit_nxt = cfg_data[RW-1:0];
        rspc_pkg::CfgStartAngle: start_nxt    = cfg_data[AW-1:0];
        rspc_pkg::CfgAngleStep:  step_nxt     = cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the offset per sample, drop back to zero after the last one of a sweep
  always_comb begin
    offset_nxt = offset_r;
    if (in_fire) begin
      offset_nxt = in_sweep_end ? '0 : offset_r + step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_limit_r <= '0;
      hi_limit_r <= '1;
      start_r    <= '0;
      step_r     <= '0;
      offset_r   <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
    end else begin
      lo_limit_r <= lo_limit_nxt;
      hi_limit_r <= hi_limit_nxt;
      start_r    <= start_nxt;
      step_r     <= step_nxt;
      offset_r   <= offset_nxt;
      if (adv) begin
        s1_vld_r <= in_fire;
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  assign prod = ProdWidth'(s1_range_r) * ProdWidth'(GainK) + ProdRound;
  assign flip = s2_theta_r[AW-1] ^ s2_theta_r[AW-2];

  // Left half-plane: rotate by half a turn, which negates the start vector
  always_comb begin
    s3_nxt      = '0;
    s3_nxt.vld  = s2_vld_r;
    s3_nxt.y    = '0;
    s3_nxt.kept = s2_kept_r;
    s3_nxt.last = s2_last_r;
    if (flip) begin
      s3_nxt.x = -XW'(s2_scaled_r);
      s3_nxt.z = ZW'($signed({~s2_theta_r[AW-1], s2_theta_r[AW-2:0]}));
    end else begin
      s3_nxt.x = XW'(s2_scaled_r);
      s3_nxt.z = ZW'($signed(s2_theta_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_range_r  <= in_range_sample;
      s1_theta_r  <= start_r + offset_r;
      s1_kept_r   <= (in_range_sample > lo_limit_r) && (in_range_sample < hi_limit_r);
      s1_last_r   <= in_sweep_end;
      s2_scaled_r <= prod[KShift +: SW];
      s2_theta_r  <= s1_theta_r;
      s2_kept_r   <= s1_kept_r;
      s2_last_r   <= s1_last_r;
      s3_r        <= s3_nxt;
    end
  end

  always_comb begin
    bus_out     = s3_r;
    bus_out.vld = s3_vld_r;
  end

`ifndef SYNTHESIS
  a_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_sweep_end) |=> (offset_r == '0))
    else $error("angle offset not cleared after last sample");
  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_sweep_end) |=> (offset_r == $past(offset_r + step_r)))
    else $error("angle offset did not advance by one step");
`endif

endmodule

// ----- src/rspc_cell.sv -----
// One CORDIC micro-rotation cell of the rotation chain.
module rspc_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  rspc_pkg::cell_bus_t bus_in,
  output rspc_pkg::cell_bus_t bus_out
);

  localparam int XW = rspc_pkg::XyWidth;
  localparam int ZW = rspc_pkg::ZWidth;
  localparam logic signed [ZW-1:0] Atan = ZW'(rspc_pkg::AtanBau[STAGE]);

  logic signed [XW-1:0] xs, ys;
  rspc_pkg::cell_bus_t  bus_nxt, bus_r;

  assign xs = bus_in.x >>> STAGE;
  assign ys = bus_in.y >>> STAGE;

  // Turn toward zero residual angle
  always_comb begin
    bus_nxt = bus_in;
    if (!bus_in.z[ZW-1]) begin
      bus_nxt.x = bus_in.x - ys;
      bus_nxt.y = bus_in.y + xs;
      bus_nxt.z = bus_in.z - Atan;
    end else begin
      bus_nxt.x = bus_in.x + ys;
      bus_nxt.y = bus_in.y - xs;
      bus_nxt.z = bus_in.z + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else if (adv) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_out = bus_r;

endmodule

// ----- src/rspc_back.sv -----
// Back end: guard-bit rounding, saturation, drop masking, output register and skid buffer.
module rspc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rspc_pkg::cell_bus_t                   bus_in,
  output logic                                  adv,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rspc_pkg::PointWidth-1:0] out_point_x,
  output logic signed [rspc_pkg::PointWidth-1:0] out_point_y,
  output logic                                  out_kept,
  output logic                                  out_sweep_done
);

  localparam int XW = rspc_pkg::XyWidth;
  localparam int EW = XW + 1;
  localparam int PW = rspc_pkg::PointWidth;
  localparam logic signed [EW-1:0] RoundHalf = EW'(1 << (rspc_pkg::GuardBits - 1));
  localparam logic signed [EW-1:0] SatMax    = EW'(rspc_pkg::XyMax);
  localparam logic signed [EW-1:0] SatMin    = EW'(rspc_pkg::XyMin);

  function automatic logic signed [PW-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [EW-1:0] t;
    t = EW'(v) + RoundHalf;
    t = t >>> rspc_pkg::GuardBits;
    if (t > SatMax) begin
      return PW'(SatMax);
    end else if (t < SatMin) begin
      return PW'(SatMin);
    end
    return PW'(t);
  endfunction

  logic                 fin_vld_r;
  logic signed [PW-1:0] fin_x_r, fin_y_r;
  logic                 fin_kept_r, fin_last_r;

  logic                 out_vld_r, out_vld_nxt;
  logic signed [PW-1:0] out_x_r, out_y_r;
  logic                 out_kept_r, out_last_r;

  logic                 skid_vld_r, skid_vld_nxt;
  logic signed [PW-1:0] skid_x_r, skid_y_r;
  logic                 skid_kept_r, skid_last_r;

  logic out_free;
  logic push;

  assign adv      = !skid_vld_r;
  assign out_free = !out_vld_r || out_ready;
  assign push     = adv && fin_vld_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r || push;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        fin_vld_r <= bus_in.vld;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_x_r    <= bus_in.kept ? finish(bus_in.x) : '0;
      fin_y_r    <= bus_in.kept ? finish(bus_in.y) : '0;
      fin_kept_r <= bus_in.kept;
      fin_last_r <= bus_in.last;
    end
    if (out_free) begin
      if (skid_vld_r) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_kept_r <= skid_kept_r;
        out_last_r <= skid_last_r;
      end else begin
        out_x_r    <= fin_x_r;
        out_y_r    <= fin_y_r;
        out_kept_r <= fin_kept_r;
        out_last_r <= fin_last_r;
      end
    end else if (push) begin
      skid_x_r    <= fin_x_r;
      skid_y_r    <= fin_y_r;
      skid_kept_r <= fin_kept_r;
      skid_last_r <= fin_last_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_kept       = out_kept_r;
  assign out_sweep_done = out_last_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while output register is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready))
    else $error("skid filled while output was free");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_kept_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("dropped point carries nonzero coordinates");
`endif

endmodule

// ----- src/range_scan_polar_to_cartesian.sv -----
// Top level of the lidar range scan polar-to-Cartesian converter.
// Usage:
//  - Input channel (in_valid/in_ready): one range sample per beat with its
//    last-of-sweep mark. Beam angle is sweep_start_angle plus a running offset
//    that grows by angle_step per beat and clears after the last beat of a sweep.
//  - Output channel (out_valid/out_ready): one point per input beat, in order,
//    with x/y saturated to signed Q9.16, kept flag, and the sweep mark copied.
//  - Config port: write cfg_data into register cfg_index while cfg_wr_en is high;
//    write only while the block is empty.
//  - Throughput: one beat per cycle while out_ready keeps up, set by the unrolled
//    chain of CORDIC_STAGES rotation cells, each holding one beat.
//  - Path: the accepting edge loads the first of three front stages; the beat
//    then passes the rotation cells, the rounding register and the output
//    register, which raises out_valid.
//  - Stall: when out_ready is low, the output register holds its beat, one more
//    beat lands in a skid register, then in_ready drops and the whole chain holds.
//  - Reset (rst_n low, synchronous): empties the pipeline, restores register
//    defaults and clears the angle offset.
module range_scan_polar_to_cartesian #(
  parameter int CORDIC_STAGES = rspc_pkg::CordicStagesDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [rspc_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [rspc_pkg::CfgDataWidth-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rspc_pkg::RangeWidth-1:0]        in_range_sample,
  input  logic                                   in_sweep_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rspc_pkg::PointWidth-1:0] out_point_x,
  output logic signed [rspc_pkg::PointWidth-1:0] out_point_y,
  output logic                                   out_kept,
  output logic                                   out_sweep_done
);

  // Global advance: the whole chain moves while the skid register is empty
  logic adv;
  rspc_pkg::cell_bus_t chain [CORDIC_STAGES+1];

  assign in_ready = adv;

  rspc_front #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_range_sample (in_range_sample),
    .in_sweep_end    (in_sweep_end),
    .bus_out         (chain[0])
  );

  // One micro-rotation per cell; each cell hands its beat to the next every cycle while adv is high
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rspc_cell #(
      .STAGE(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .bus_in  (chain[i]),
      .bus_out (chain[i+1])
    );
  end

  rspc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .bus_in         (chain[CORDIC_STAGES]),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_kept       (out_kept),
    .out_sweep_done (out_sweep_done)
  );

endmodule

// ----- test/tb_range_scan_polar_to_cartesian.sv -----
// Testbench for the range scan polar-to-Cartesian converter: directed and random sweeps.
module tb_range_scan_polar_to_cartesian;

  localparam int Stages       = 16;
  localparam int Guard        = 6;
  localparam int Latency      = Stages + 5;
  localparam int CycleLimit   = 200000;
  localparam int PrintCap     = 50;
  localparam logic [23:0] RangeMax = 24'hFFFFFF;
  localparam longint PointMax = 16777215;
  localparam longint PointMin = -16777216;

  // Arctangent of 2^-i in binary angle units, one entry per rotation stage
  localparam longint ArctanBau [Stages] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic               kept;
    logic               done;
  } point_t;

  // DUT ports; every input starts at a known value
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  rspc_pkg::cfg_index_t cfg_index = rspc_pkg::CfgLowerLimit;
  logic [31:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [23:0]       in_range_sample = '0;
  logic              in_sweep_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [24:0] out_point_x;
  logic signed [24:0] out_point_y;
  logic              out_kept;
  logic              out_sweep_done;

  // Mirror of the block's registers and running angle
  logic [23:0]       lower_limit = 24'd0;
  logic [23:0]       upper_limit = RangeMax;
  logic [31:0]       start_angle = 32'd0;
  logic [31:0]       angle_step = 32'd0;
  logic [31:0]       beam_offset = 32'd0;
  longint unsigned   gain_q30;

  point_t            pending_points[$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatch_count = 0;
  int                samples_sent = 0;
  int                sweeps_sent = 0;
  int                points_checked = 0;
  int                kept_seen = 0;
  int                cycle_count = 0;

  range_scan_polar_to_cartesian i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_range_sample(in_range_sample),
    .in_sweep_end   (in_sweep_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_kept       (out_kept),
    .out_sweep_done (out_sweep_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reciprocal of the CORDIC gain in Q2.30: 2^30 / sqrt(prod(1 + 4^-i)), rounded.
  // Start from a floating point root and nudge it to the exact integer floor.
  function automatic longint unsigned cordic_gain_q30();
    longint unsigned p;
    longint unsigned s;
    p = 64'd1 << 60;
    for (int i = 0; i < Stages; i++) p = p + (p >> (2 * i));
    s = longint'($sqrt(real'(p)));
    while (s * s > p) s--;
    while ((s + 1) * (s + 1) <= p) s++;
    return ((64'd1 << 60) + s / 2) / s;
  endfunction

  // Drop the guard bits with round half up, then clamp to signed Q9.16.
  function automatic logic signed [24:0] round_clamp(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (Guard - 1))) >>> Guard;
    if (r > PointMax) r = PointMax;
    if (r < PointMin) r = PointMin;
    return r[24:0];
  endfunction

  // Expected point for one accepted sample; advances or clears the beam offset.
  function automatic point_t convert_sample(input logic [23:0] range_q, input logic last);
    point_t      pt;
    logic [31:0] theta;
    logic [31:0] flipped;
    logic        keep;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    theta = start_angle + beam_offset;
    keep  = (range_q > lower_limit) && (range_q < upper_limit);
    // prescale by the gain reciprocal, keeping the guard bits
    x = longint'((64'(range_q) * gain_q30 + (64'd1 << (29 - Guard))) >> (30 - Guard));
    y = 0;
    // left half-plane: rotate the start vector by a half turn first
    if (theta[31:30] == 2'b01 || theta[31:30] == 2'b10) begin
      x       = -x;
      flipped = theta ^ 32'h8000_0000;
      z       = longint'($signed(flipped));
    end else begin
      z = longint'($signed(theta));
    end
    for (int i = 0; i < Stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ArctanBau[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ArctanBau[i];
      end
    end
    pt.x    = keep ? round_clamp(x) : '0;
    pt.y    = keep ? round_clamp(y) : '0;
    pt.kept = keep;
    pt.done = last;
    if (last) beam_offset = 32'd0;
    else      beam_offset = beam_offset + angle_step;
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PrintCap) begin
      $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    end
    mismatch_count++;
  endtask

  // Write all four registers back to back; call only with the pipeline empty.
  // High bits above a 24-bit limit are junk on purpose: the block must ignore them.
  task automatic load_config(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] start, input logic [31:0] step);
    cfg_wr_en <= 1'b1;
    cfg_index <= rspc_pkg::CfgLowerLimit;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= rspc_pkg::CfgUpperLimit;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= rspc_pkg::CfgStartAngle;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= rspc_pkg::CfgAngleStep;
    cfg_data  <= step;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    lower_limit = lo[23:0];
    upper_limit = hi[23:0];
    start_angle = start;
    angle_step  = step;
  endtask

  // Present one beat, idling first at the current sender rate, and hold it
  // until the block takes it. Leaves in_valid high; the caller lowers it.
  task automatic send_sample(input logic [23:0] range_q, input logic last);
    point_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_range_sample <= range_q;
    in_sweep_end    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected       = convert_sample(range_q, last);
    pending_points = {pending_points, expected};
    samples_sent++;
    if (last) sweeps_sent++;
  endtask

  // Hold off until every expected point has come out.
  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // Ranges biased toward the limits and the field extremes.
  function automatic logic [23:0] pick_range();
    int unsigned sel;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = longint'($urandom_range(RangeMax));
    end else if (sel < 60) begin
      v = longint'(lower_limit) + longint'($urandom_range(4)) - 2;
    end else if (sel < 80) begin
      v = longint'(upper_limit) + longint'($urandom_range(4)) - 2;
    end else if (sel < 90) begin
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 1;
        2:       v = longint'(RangeMax) - 1;
        default: v = longint'(RangeMax);
      endcase
    end else begin
      v = longint'($urandom_range(65535));
    end
    if (v < 0) v = 0;
    if (v > longint'(RangeMax)) v = longint'(RangeMax);
    return v[23:0];
  endfunction

  // Register settings for one random segment:
  //   0 random ordered limits, any angles
  //   1 widest window, start at the half turn, largest positive step
  //   2 lower limit above upper limit, most negative step
  //   3 narrow margins, small signed step as a real sweep would use
  task automatic random_config(input int kind);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] step;
    case (kind)
      0: begin
        a = $urandom_range(RangeMax);
        b = $urandom_range(RangeMax);
        if (a > b) begin
          step = a;
          a    = b;
          b    = step;
        end
        load_config({8'($urandom), a[23:0]}, {8'($urandom), b[23:0]}, $urandom, $urandom);
      end
      1: load_config(32'd0, {8'hA5, RangeMax}, 32'h8000_0000, 32'h7FFF_FFFF);
      2: load_config({8'h00, RangeMax}, 32'hFF00_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      default: begin
        step = $urandom_range(32'h0020_0000);
        if ($urandom_range(1)) step = -step;
        load_config($urandom_range(2000), RangeMax - $urandom_range(2000), $urandom, step);
      end
    endcase
  endtask

  // Sweeps of random length; a few stray end marks break sweeps early.
  task automatic send_sweeps(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 40);
      for (int j = 0; j < len && sent < count; j++) begin
        send_sample(pick_range(), (j == len - 1) || ($urandom_range(99) < 3));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // Defaults after reset: zero, the smallest kept range, the largest kept
  // range at angle zero (x near full scale) and the maximum, which the reset
  // upper limit still drops.
  task automatic test_range_extremes();
    send_sample(24'd0, 1'b0);
    send_sample(24'd1, 1'b0);
    send_sample(RangeMax - 1, 1'b0);
    send_sample(RangeMax, 1'b1);
    in_valid <= 1'b0;
  endtask

  // Angles on both sides of each quadrant border at full range, with the
  // offset wrapping past a full turn.
  task automatic test_quadrant_edges();
    wait_drained();
    load_config(32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000);
    for (int i = 0; i < 5; i++) send_sample(RangeMax - 1, i == 4);
    in_valid <= 1'b0;
    wait_drained();
    load_config(32'd0, {8'd0, RangeMax}, 32'd0, 32'h4000_0000);
    for (int i = 0; i < 4; i++) send_sample(RangeMax - 1 - 24'(i), i == 3);
    in_valid <= 1'b0;
  endtask

  // Limits equal (nothing kept), then a window of width one.
  task automatic test_limit_edges();
    wait_drained();
    load_config(32'd1000, 32'd1000, 32'h2000_0000, 32'h0100_0000);
    send_sample(24'd999, 1'b0);
    send_sample(24'd1000, 1'b0);
    send_sample(24'd1001, 1'b1);
    in_valid <= 1'b0;
    wait_drained();
    load_config(32'd1000, 32'd1002, 32'h1234_5678, -32'sd5);
    send_sample(24'd1000, 1'b0);
    send_sample(24'd1001, 1'b0);
    send_sample(24'd1002, 1'b1);
    in_valid <= 1'b0;
  endtask

  // Two random segments under one idling mode, with a register change between.
  task automatic test_random_sweeps(input int send_pct, input int recv_pct,
                                    input int kind_a, input int count_a,
                                    input int kind_b, input int count_b);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wait_drained();
    random_config(kind_a);
    send_sweeps(count_a);
    wait_drained();
    random_config(kind_b);
    send_sweeps(count_b);
  endtask

  // Receiver: stall at the current rate, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted point with the oldest expectation.
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point, x", out_point_x, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
        if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
        if (out_kept !== want.kept) report_mismatch("kept", out_kept, want.kept);
        if (out_sweep_done !== want.done) report_mismatch("sweep_done", out_sweep_done, want.done);
        points_checked++;
        if (want.kept) kept_seen++;
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d points outstanding",
               cycle_count, pending_points.size());
      $display("tb_range_scan_polar_to_cartesian failed");
      $finish;
    end
  end

  initial begin
    gain_q30 = cordic_gain_q30();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full speed for the directed part
    test_range_extremes();
    test_quadrant_edges();
    test_limit_edges();

    // sender sparse and receiver mostly stalled, then swapped, then back to back
    test_random_sweeps(29, 81, 0, 100, 3, 100);
    test_random_sweeps(81, 29, 1, 100, 0, 100);
    test_random_sweeps(0, 0, 3, 100, 2, 30);

    wait_drained();
    repeat (Latency + 10) @(posedge clk);

    $display("covered %0d samples in %0d sweeps, %0d points checked, %0d kept",
             samples_sent, sweeps_sent, points_checked, kept_seen);
    $display("limits, quadrant borders, offset wrap and three idling mixes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("tb_range_scan_polar_to_cartesian passed");
    end else begin
      $display("tb_range_scan_polar_to_cartesian failed");
    end
    $finish;
  end

endmodule
